FILE: hw/rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_HEAD = 3'd0,
        CMD_PUSH_TAIL = 3'd1,
        CMD_INSERT    = 3'd2,
        CMD_REMOVE    = 3'd3,
        CMD_POP_HEAD  = 3'd4,
        CMD_POP_TAIL  = 3'd5,
        CMD_READ      = 3'd6,
        CMD_CLEAR     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUT,
        OP_TAKE,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DOWN,
        S_READ_WAIT
    } state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [LEN_W-1:0]   position;
        logic signed [WORD_W-1:0] value;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic signed [WORD_W-1:0] read_value;
        logic [LEN_W-1:0]   length;
    } out_t;

    // Decoded command: what to do and where, after the range checks.
    typedef struct packed {
        op_t                op;
        status_t            status;
        logic [LEN_W-1:0]   pos;
    } plan_t;

endpackage

FILE: hw/rtl/ile_check.sv
// Command decode and range checks against the current list length.
module ile_check
    import ile_pkg::*;
(
    input  in_t              command,
    input  logic [LEN_W-1:0] count,
    output plan_t            plan
);

    always_comb
    begin
        plan.op     = OP_NONE;
        plan.status = ST_OK;
        plan.pos    = '0;
        unique case (command.cmd)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_INSERT:
            begin
                if (command.cmd == CMD_PUSH_HEAD)
                    plan.pos = '0;
                else if (command.cmd == CMD_PUSH_TAIL)
                    plan.pos = count;
                else
                    plan.pos = command.position;
                // index check comes before the full check
                if (plan.pos > count)
                    plan.status = ST_INDEX;
                else if (count >= LEN_W'(CAPACITY))
                    plan.status = ST_FULL;
                else
                    plan.op = OP_PUT;
            end
            CMD_REMOVE, CMD_POP_HEAD, CMD_POP_TAIL:
            begin
                if (command.cmd == CMD_POP_HEAD)
                    plan.pos = '0;
                else if (command.cmd == CMD_POP_TAIL)
                    plan.pos = count - LEN_W'(1);
                else
                    plan.pos = command.position;
                if (count == '0)
                    plan.status = ST_EMPTY;
                else if (plan.pos >= count)
                    plan.status = ST_INDEX;
                else
                    plan.op = OP_TAKE;
            end
            CMD_READ:
            begin
                plan.pos = command.position;
                if (count == '0)
                    plan.status = ST_EMPTY;
                else if (plan.pos >= count)
                    plan.status = ST_INDEX;
                else
                    plan.op = OP_READ;
            end
            CMD_CLEAR:
            begin
                plan.op = OP_CLEAR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/indexed_list_engine_core.sv
// Indexed list engine top level: element memory, shift sequencer and result register.
//
// Ordered list of up to 64 signed 32-bit words held in one synchronous RAM
// (one write and one read per cycle, read data registered).
// Command channel: present a transaction on command and raise start; it is
// taken at a clock edge where busy is low. busy stays high while a shift or a read runs.
// Result channel: done pulses for one cycle with status, read_value and the
// new length on result. Every command gives exactly one result.
// Errors, clear, an append at the end and removal of the last word finish
// straight from idle; a read passes through the read wait state. An insert
// at index i below the end moves each word from the last down to index i
// up by one (one RAM move per cycle), then places the new word. A remove
// below the last word moves each word above index i down by one (one RAM move per cycle).
// The next command may be accepted in the cycle done is shown.
// Reset empties the list at once; RAM contents are not cleared since only
// entries below the length are ever read. The receiver cannot stall: each
// result is flagged by done for a single cycle only.
module indexed_list_engine_core
    import ile_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  command,
    output logic done,
    output out_t result
);

    state_t                state_reg, state_next;
    logic [LEN_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic [WORD_W-1:0]     value_reg, value_next;
    logic                  done_reg, done_next;
    out_t                  result_reg, result_next;

    logic [WORD_W-1:0]     mem [CAPACITY];
    logic [WORD_W-1:0]     rd_data_reg;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [WORD_W-1:0]     mem_wdata;

    plan_t                 plan;
    logic                  accept;
    logic [ADDR_W-1:0]     last_idx;

    ile_check u_check (
        .command (command),
        .count   (count_reg),
        .plan    (plan)
    );

    assign accept   = start && (state_reg == S_IDLE);
    assign last_idx = ADDR_W'(count_reg - LEN_W'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (plan.op)
                        OP_PUT:
                            if (plan.pos != count_reg)
                                state_next = S_SHIFT_UP;
                        OP_TAKE:
                            if (plan.pos != count_reg - LEN_W'(1))
                                state_next = S_SHIFT_DOWN;
                        OP_READ:
                            state_next = S_READ_WAIT;
                        OP_NONE, OP_CLEAR:
                            state_next = S_IDLE;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                if (addr_reg == pos_reg)
                    state_next = S_PLACE;
            end
            S_PLACE:
                state_next = S_IDLE;
            S_SHIFT_DOWN:
            begin
                if (addr_reg == last_idx)
                    state_next = S_IDLE;
            end
            S_READ_WAIT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next  = count_reg;
        addr_next   = addr_reg;
        pos_next    = pos_reg;
        value_next  = value_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = value_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next               = ADDR_W'(plan.pos);
                    value_next             = command.value;
                    result_next.status     = plan.status;
                    result_next.read_value = '0;
                    result_next.length     = count_reg;
                    unique case (plan.op)
                        OP_PUT:
                        begin
                            if (plan.pos == count_reg)
                            begin
                                // append needs no shift
                                mem_we             = 1'b1;
                                mem_waddr          = ADDR_W'(plan.pos);
                                mem_wdata          = command.value;
                                count_next         = count_reg + LEN_W'(1);
                                result_next.length = count_reg + LEN_W'(1);
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = last_idx;
                                addr_next = last_idx;
                            end
                        end
                        OP_TAKE:
                        begin
                            if (plan.pos == count_reg - LEN_W'(1))
                            begin
                                count_next         = count_reg - LEN_W'(1);
                                result_next.length = count_reg - LEN_W'(1);
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = ADDR_W'(plan.pos) + ADDR_W'(1);
                                addr_next = ADDR_W'(plan.pos) + ADDR_W'(1);
                            end
                        end
                        OP_READ:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = ADDR_W'(plan.pos);
                        end
                        OP_CLEAR:
                        begin
                            count_next         = '0;
                            result_next.length = '0;
                            done_next          = 1'b1;
                        end
                        OP_NONE:
                            done_next = 1'b1;
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                // move entry addr_reg up by one, walking toward the insert point
                mem_we    = 1'b1;
                mem_waddr = addr_reg + ADDR_W'(1);
                mem_wdata = rd_data_reg;
                if (addr_reg != pos_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = addr_reg - ADDR_W'(1);
                    addr_next = addr_reg - ADDR_W'(1);
                end
            end
            S_PLACE:
            begin
                mem_we             = 1'b1;
                mem_waddr          = pos_reg;
                mem_wdata          = value_reg;
                count_next         = count_reg + LEN_W'(1);
                result_next.length = count_reg + LEN_W'(1);
                done_next          = 1'b1;
            end
            S_SHIFT_DOWN:
            begin
                // move entry addr_reg down by one, walking toward the tail
                mem_we    = 1'b1;
                mem_waddr = addr_reg - ADDR_W'(1);
                mem_wdata = rd_data_reg;
                if (addr_reg == last_idx)
                begin
                    count_next         = count_reg - LEN_W'(1);
                    result_next.length = count_reg - LEN_W'(1);
                    done_next          = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = addr_reg + ADDR_W'(1);
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            S_READ_WAIT:
            begin
                result_next.read_value = rd_data_reg;
                done_next              = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sim/indexed_list_engine_core_tb.sv
// Self-checking testbench for the indexed list engine core.
module indexed_list_engine_core_tb
    import ile_pkg::*;
();

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  command;
    logic done;
    out_t result;

    // Predicted list contents, front at index 0.
    logic signed [WORD_W-1:0] list_words[$];
    // Results owed by the block, oldest first.
    out_t pending_results[$];
    int   err_count;
    int   idle_pct;

    indexed_list_engine_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("indexed_list_engine_core test failed");
        $finish;
    end

    // Applies one command to the predicted list and returns its result.
    function automatic out_t predict_list_op(input in_t c);
        out_t    r;
        int      n;
        int      pos;
        status_t st;
        n            = list_words.size();
        pos          = int'(c.position);
        st           = ST_OK;
        r.read_value = '0;
        case (c.cmd)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_INSERT:
            begin
                if (c.cmd == CMD_PUSH_HEAD)
                    pos = 0;
                else if (c.cmd == CMD_PUSH_TAIL)
                    pos = n;
                // index check wins over the full check
                if (pos > n)
                    st = ST_INDEX;
                else if (n >= CAPACITY)
                    st = ST_FULL;
                else
                    list_words.insert(pos, c.value);
            end
            CMD_REMOVE, CMD_POP_HEAD, CMD_POP_TAIL:
            begin
                if (c.cmd == CMD_POP_HEAD)
                    pos = 0;
                else if (c.cmd == CMD_POP_TAIL)
                    pos = n - 1;
                if (n == 0)
                    st = ST_EMPTY;
                else if (pos >= n)
                    st = ST_INDEX;
                else
                    list_words.delete(pos);
            end
            CMD_READ:
            begin
                if (n == 0)
                    st = ST_EMPTY;
                else if (pos >= n)
                    st = ST_INDEX;
                else
                    r.read_value = list_words[pos];
            end
            default:
                list_words.delete();
        endcase
        r.status = st;
        r.length = LEN_W'(list_words.size());
        return r;
    endfunction

    function automatic in_t make_cmd(input cmd_t op, input int pos, input logic [WORD_W-1:0] word);
        in_t c;
        c.cmd      = op;
        c.position = LEN_W'(pos);
        c.value    = word;
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // grow_pct biases toward adding words; positions are mostly legal for the current length.
    function automatic in_t random_cmd(input int grow_pct, input bit allow_clear);
        in_t c;
        int  n;
        int  r;
        n       = list_words.size();
        c.value = random_word();
        r       = $urandom_range(0, 199);
        if (allow_clear && r == 0)
            c.cmd = CMD_CLEAR;
        else if ($urandom_range(0, 99) < grow_pct)
        begin
            case ($urandom_range(0, 2))
                0:       c.cmd = CMD_PUSH_HEAD;
                1:       c.cmd = CMD_PUSH_TAIL;
                default: c.cmd = CMD_INSERT;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       c.cmd = CMD_REMOVE;
                1:       c.cmd = CMD_POP_HEAD;
                2:       c.cmd = CMD_POP_TAIL;
                default: c.cmd = CMD_READ;
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            c.position = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
        else if (c.cmd == CMD_INSERT)
            c.position = LEN_W'($urandom_range(0, n));
        else
            c.position = (n == 0) ? '0 : LEN_W'($urandom_range(0, n - 1));
        return c;
    endfunction

    // Holds start high until the block takes the transaction, then records its result.
    task automatic issue_command(input in_t c);
        out_t expected;
        command <= c;
        start   <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        expected        = predict_list_op(c);
        pending_results = {pending_results, expected};
    endtask

    task automatic pace();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic send(input in_t c);
        issue_command(c);
        pace();
    endtask

    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, result);
                err_count++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             result.status);
                    err_count++;
                end
                if (result.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %h got %h", $time, want.read_value,
                             result.read_value);
                    err_count++;
                end
                if (result.length !== want.length)
                begin
                    $display("%0t: length expected %0d got %0d", $time, want.length,
                             result.length);
                    err_count++;
                end
            end
        end
    end

    task automatic test_empty_list();
        send(make_cmd(CMD_READ, 0, '0));
        send(make_cmd(CMD_REMOVE, 0, '0));
        send(make_cmd(CMD_POP_HEAD, 0, '0));
        send(make_cmd(CMD_POP_TAIL, 0, '0));
        send(make_cmd(CMD_CLEAR, 0, '0));
    endtask

    task automatic test_each_command();
        send(make_cmd(CMD_PUSH_TAIL, 127, 32'h7fff_ffff));
        send(make_cmd(CMD_PUSH_HEAD, 0, 32'h8000_0000));
        send(make_cmd(CMD_INSERT, 1, 32'h0000_0000));
        send(make_cmd(CMD_INSERT, 3, 32'hffff_ffff));   // append through insert
        send(make_cmd(CMD_INSERT, 5, 32'h5555_5555));   // past the end
        send(make_cmd(CMD_INSERT, 127, 32'haaaa_aaaa));
        send(make_cmd(CMD_READ, 0, '0));
        send(make_cmd(CMD_READ, 1, '0));
        send(make_cmd(CMD_READ, 2, '0));
        send(make_cmd(CMD_READ, 3, '0));
        send(make_cmd(CMD_READ, 4, '0));                // one past the end
        send(make_cmd(CMD_READ, 127, '0));
        send(make_cmd(CMD_REMOVE, 4, '0));
        send(make_cmd(CMD_REMOVE, 1, '0));
        send(make_cmd(CMD_POP_HEAD, 0, '0));
        send(make_cmd(CMD_POP_TAIL, 0, '0));
        send(make_cmd(CMD_CLEAR, 0, '0));
    endtask

    // Drive the list to capacity, keep it pinned there, then drain it.
    task automatic test_fill_and_drain(input int rounds);
        int guard;
        repeat (rounds)
        begin
            guard = 0;
            while (list_words.size() < CAPACITY && guard < 400)
            begin
                send(random_cmd(90, 1'b0));
                guard++;
            end
            repeat (25) send(random_cmd(85, 1'b0));
            guard = 0;
            while (list_words.size() != 0 && guard < 400)
            begin
                send(random_cmd(10, 1'b0));
                guard++;
            end
            repeat (10) send(random_cmd(20, 1'b0));
        end
    endtask

    task automatic test_mixed_traffic(input int items);
        for (int i = 0; i < items; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            send(random_cmd($urandom_range(35, 65), 1'b1));
        end
    endtask

    task automatic test_back_to_back(input int items);
        idle_pct = 0;
        repeat (items / 2) send(random_cmd(70, 1'b0));
        repeat (items / 2) send(random_cmd(40, 1'b1));
    endtask

    initial
    begin
        err_count = 0;
        idle_pct  = 30;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        command <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_each_command();
        test_fill_and_drain(3);
        test_mixed_traffic(400);
        test_back_to_back(160);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (err_count == 0)
            $display("indexed_list_engine_core test passed");
        else
            $display("indexed_list_engine_core test failed");
        $finish;
    end

endmodule
